[src/assert_macros.svh]
// Assertion macros shared by the UUID text parser RTL.
// Included by the modules that carry concurrent checks; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, masked while reset is high.
`define UUIDP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication: the consequent must hold on the cycle after the antecedent.
`define UUIDP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/uuidp_pkg.sv]
// Types, constants and the hex digit decoder of the UUID text parser.
// Has no dependencies; used by every module except uuidp_port_check.
`timescale 1ns / 1ps

package uuidp_pkg;

   localparam logic [4:0] UUID_BYTES   = 5'd16;
   localparam logic [7:0] HYPHEN_CHAR  = 8'h2D;
   localparam logic [7:0] DIGIT_ZERO   = 8'h30;
   localparam logic [7:0] DIGIT_NINE   = 8'h39;
   localparam logic [7:0] LOWER_A      = 8'h61;
   localparam logic [7:0] LOWER_F      = 8'h66;
   localparam logic [7:0] UPPER_A      = 8'h41;
   localparam logic [7:0] UPPER_F      = 8'h46;
   localparam logic [4:0] DIGIT_BAD    = 5'd16;

   // One character of text with its end-of-string flag
   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } char_type;

   // Input register contents handed to the parse core
   typedef struct packed {
      logic     valid;
      char_type item;
   } stage_type;

   // Map a character to its digit value, or DIGIT_BAD for a non-hex character
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= DIGIT_ZERO && c <= DIGIT_NINE) begin
         d = c - DIGIT_ZERO;
         return d[4:0];
      end
      if (c >= LOWER_A && c <= LOWER_F) begin
         d = c - LOWER_A + 8'd10;
         return d[4:0];
      end
      if (c >= UPPER_A && c <= UPPER_F) begin
         d = c - UPPER_A + 8'd10;
         return d[4:0];
      end
      return DIGIT_BAD;
   endfunction

endpackage

[src/uuidp_if.sv]
// Valid/ready channel interfaces of the UUID text parser: request and response.
// Depends on uuidp_pkg for nothing but shares the project style.
`timescale 1ns / 1ps

interface uuidp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface uuidp_rsp_if;
   logic        valid;
   logic        ready;
   logic        parse_ok;
   logic [63:0] uuid_high;
   logic [63:0] uuid_low;

   modport source (output valid, output parse_ok, output uuid_high, output uuid_low,
                   input ready);
   modport sink   (input valid, input parse_ok, input uuid_high, input uuid_low,
                   output ready);
endinterface

[src/uuid_text_parser.sv]
// Top level of the UUID text parser: input register, parse core, port checks.
// Depends on uuidp_pkg, uuidp_if.sv, uuidp_in_reg, uuidp_core and uuidp_port_check.
//
//   Port      Dir   Carries
//   req_bus   in    character (8b), last_char (1b), valid/ready
//   rsp_bus   out   parse_ok (1b), uuid_high (64b), uuid_low (64b), valid/ready
//
// One character per cycle is accepted unless a stalled response holds a last
// character; a response passes the input register, then the response register.
// A single parse step lies between the two registers.
// Reset is synchronous and clears all parser state and both valid flags.
// A stalled response holds only a last character in the input register, and the
// input behind it; other characters keep flowing.
`timescale 1ns / 1ps

module uuid_text_parser (
   input  logic        clock,
   input  logic        reset,
   uuidp_req_if.sink   req_bus,
   uuidp_rsp_if.source rsp_bus
);

   uuidp_pkg::stage_type stage;
   logic                 advance;

   // Capture incoming characters
   uuidp_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .advance (advance),
      .stage   (stage)
   );

   // Parse and hold the response
   uuidp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .rsp_bus (rsp_bus)
   );

   // Watch the ports
   uuidp_port_check u_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_last  (req_bus.last_char),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready)
   );

endmodule

[src/uuidp_in_reg.sv]
// Input register of the UUID text parser: captures one request per cycle unless the held one stalls.
// Depends on uuidp_pkg and the request interface in uuidp_if.sv.
`timescale 1ns / 1ps

module uuidp_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   uuidp_req_if.sink             req_bus,
   input  logic                  advance,
   output uuidp_pkg::stage_type  stage
);

   logic                 valid_ff;
   logic                 valid_in;
   uuidp_pkg::char_type  item_ff;
   uuidp_pkg::char_type  item_in;
   logic                 take;

   // Accept when empty or when the held character moves on this cycle
   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   // Load a new character, or drop the held one once it advances
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in          = 1'b1;
         item_in.character = req_bus.character;
         item_in.last_char = req_bus.last_char;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

[src/uuidp_core.sv]
// Parse core: per-character state update and the response register.
// Depends on uuidp_pkg, the response interface and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uuidp_core (
   input  logic                  clock,
   input  logic                  reset,
   input  uuidp_pkg::stage_type  stage,
   output logic                  advance,
   uuidp_rsp_if.source           rsp_bus
);

   logic [4:0]  bytes_done_ff,    bytes_done_in;
   logic        second_nibble_ff, second_nibble_in;
   logic        hyphen_taken_ff,  hyphen_taken_in;
   logic        error_seen_ff,    error_seen_in;
   logic [63:0] high_ff,          high_in;
   logic [63:0] low_ff,           low_in;
   logic        out_valid_ff,     out_valid_in;
   logic        parse_ok_ff,      parse_ok_in;
   logic [63:0] uuid_high_ff,     uuid_high_in;
   logic [63:0] uuid_low_ff,      uuid_low_in;
   logic [4:0]  digit;
   logic        is_hyphen;
   logic        ok;

   // A last character needs the response register free; others always move
   assign advance = stage.valid &&
                    (!stage.item.last_char || !out_valid_ff || rsp_bus.ready);

   assign digit     = uuidp_pkg::hex_digit(stage.item.character);
   assign is_hyphen = (stage.item.character == uuidp_pkg::HYPHEN_CHAR);

   // Step the parser by one character
   always_comb begin
      bytes_done_in    = bytes_done_ff;
      second_nibble_in = second_nibble_ff;
      hyphen_taken_in  = hyphen_taken_ff;
      error_seen_in    = error_seen_ff;
      high_in          = high_ff;
      low_in           = low_ff;
      if (!error_seen_ff) begin
         if (bytes_done_ff >= uuidp_pkg::UUID_BYTES) begin
            if (!is_hyphen) error_seen_in = 1'b1;
         end else if (!second_nibble_ff && is_hyphen) begin
            if (hyphen_taken_ff) error_seen_in = 1'b1;
            else                 hyphen_taken_in = 1'b1;
         end else if (digit == uuidp_pkg::DIGIT_BAD) begin
            error_seen_in = 1'b1;
         end else begin
            high_in = {high_ff[59:0], low_ff[63:60]};
            low_in  = {low_ff[59:0], digit[3:0]};
            if (second_nibble_ff) begin
               second_nibble_in = 1'b0;
               hyphen_taken_in  = 1'b0;
               bytes_done_in    = bytes_done_ff + 5'd1;
            end else begin
               second_nibble_in = 1'b1;
            end
         end
      end
   end

   assign ok = !error_seen_in && (bytes_done_in == uuidp_pkg::UUID_BYTES) &&
               !second_nibble_in;

   // Load the response on the last character; release it when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      parse_ok_in  = parse_ok_ff;
      uuid_high_in = uuid_high_ff;
      uuid_low_in  = uuid_low_ff;
      if (rsp_bus.ready) out_valid_in = 1'b0;
      if (advance && stage.item.last_char) begin
         out_valid_in = 1'b1;
         parse_ok_in  = ok;
         uuid_high_in = ok ? high_in : 64'd0;
         uuid_low_in  = ok ? low_in  : 64'd0;
      end
   end

   // Parser state: advance per character, clear after the last one
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_done_ff    <= 5'd0;
         second_nibble_ff <= 1'b0;
         hyphen_taken_ff  <= 1'b0;
         error_seen_ff    <= 1'b0;
         high_ff          <= 64'd0;
         low_ff           <= 64'd0;
         out_valid_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance && stage.item.last_char) begin
            bytes_done_ff    <= 5'd0;
            second_nibble_ff <= 1'b0;
            hyphen_taken_ff  <= 1'b0;
            error_seen_ff    <= 1'b0;
            high_ff          <= 64'd0;
            low_ff           <= 64'd0;
         end else if (advance) begin
            bytes_done_ff    <= bytes_done_in;
            second_nibble_ff <= second_nibble_in;
            hyphen_taken_ff  <= hyphen_taken_in;
            error_seen_ff    <= error_seen_in;
            high_ff          <= high_in;
            low_ff           <= low_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      parse_ok_ff  <= parse_ok_in;
      uuid_high_ff <= uuid_high_in;
      uuid_low_ff  <= uuid_low_in;
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.parse_ok  = parse_ok_ff;
   assign rsp_bus.uuid_high = uuid_high_ff;
   assign rsp_bus.uuid_low  = uuid_low_ff;

   `UUIDP_ASSERT(a_byte_count_range, clock, reset,
      bytes_done_ff <= uuidp_pkg::UUID_BYTES, "byte count past sixteen")
   `UUIDP_ASSERT(a_nibble_needs_room, clock, reset,
      !second_nibble_ff || (bytes_done_ff < uuidp_pkg::UUID_BYTES),
      "half byte after sixteen bytes")
   `UUIDP_ASSERT(a_failed_is_zero, clock, reset,
      !out_valid_ff || parse_ok_ff || (uuid_high_ff == 64'd0 && uuid_low_ff == 64'd0),
      "failed response carries a value")
   `UUIDP_ASSERT_NEXT(a_clear_after_last, clock, reset,
      advance && stage.item.last_char,
      bytes_done_ff == 5'd0 && !second_nibble_ff && !hyphen_taken_ff &&
      !error_seen_ff && out_valid_ff,
      "state not cleared after last character")

endmodule

[src/uuidp_top_dummy_guard.sv]
// Response-side occupancy check of the UUID text parser, port view only.
// Depends on assert_macros.svh only.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uuidp_port_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready
);

   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       last_in;
   logic       last_out;

   // Count last characters accepted whose response is not yet taken
   assign last_in  = req_valid && req_ready && req_last;
   assign last_out = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      case ({last_in, last_out})
         2'b10:   pending_in = pending_ff + 2'd1;
         2'b01:   pending_in = pending_ff - 2'd1;
         default: pending_in = pending_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `UUIDP_ASSERT(a_no_spurious_rsp, clock, reset,
      !rsp_valid || pending_ff != 2'd0, "response without a finished string")
   `UUIDP_ASSERT(a_pending_bound, clock, reset,
      pending_ff <= 2'd2, "more than two strings in flight")
   `UUIDP_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

endmodule

[tb/sv/uuidp_checker.sv]
// Response checker for the UUID text parser: predicts one result per string and compares.
// Depends on uuidp_pkg for its constants; watches both channels passively.
`timescale 1ns / 1ps

module uuidp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_character,
   input  logic        req_last_char,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_parse_ok,
   input  logic [63:0] rsp_uuid_high,
   input  logic [63:0] rsp_uuid_low,
   output int          error_count,
   output int          pending_count
);

   typedef struct packed {
      logic        ok;
      logic [63:0] high;
      logic [63:0] low;
   } uuid_result_type;

   // expected parse results, oldest first
   uuid_result_type pending_uuids[$];

   // predicted parser state
   logic [4:0]   pairs_done;
   logic         mid_pair;
   logic         dash_before;
   logic         string_bad;
   logic [127:0] digits;

   int fails = 0;
   int waiting = 0;

   assign error_count   = fails;
   assign pending_count = waiting;

   // Fold case with bit 5: only 'A'..'F' and 'a'..'f' land in 'a'..'f'
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      if (c >= uuidp_pkg::DIGIT_ZERO && c <= uuidp_pkg::DIGIT_NINE)
         return {1'b0, c[3:0]};
      if (folded >= uuidp_pkg::LOWER_A && folded <= uuidp_pkg::LOWER_F)
         return {1'b0, folded[3:0]} + 5'd9;
      return uuidp_pkg::DIGIT_BAD;
   endfunction

   function automatic void clear_parser();
      pairs_done  = '0;
      mid_pair    = 1'b0;
      dash_before = 1'b0;
      string_bad  = 1'b0;
      digits      = '0;
   endfunction

   // Advance the parser by one character; on the last one queue the result
   function automatic void parse_char(input logic [7:0] c, input logic last);
      logic [4:0]      nib;
      uuid_result_type r;
      nib = nibble_of(c);
      if (!string_bad) begin
         if (pairs_done >= uuidp_pkg::UUID_BYTES) begin
            // only hyphens may trail a complete value
            if (c != uuidp_pkg::HYPHEN_CHAR) string_bad = 1'b1;
         end else if (!mid_pair) begin
            if (c == uuidp_pkg::HYPHEN_CHAR) begin
               if (dash_before) string_bad = 1'b1;
               else dash_before = 1'b1;
            end else if (nib == uuidp_pkg::DIGIT_BAD) begin
               string_bad = 1'b1;
            end else begin
               digits   = {digits[123:0], nib[3:0]};
               mid_pair = 1'b1;
            end
         end else if (nib == uuidp_pkg::DIGIT_BAD) begin
            string_bad = 1'b1;
         end else begin
            digits      = {digits[123:0], nib[3:0]};
            mid_pair    = 1'b0;
            dash_before = 1'b0;
            pairs_done  = pairs_done + 5'd1;
         end
      end
      if (last) begin
         r.ok   = !string_bad && pairs_done == uuidp_pkg::UUID_BYTES && !mid_pair;
         r.high = r.ok ? digits[127:64] : 64'd0;
         r.low  = r.ok ? digits[63:0] : 64'd0;
         pending_uuids.push_back(r);
         clear_parser();
      end
   endfunction

   // Predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      uuid_result_type want;
      if (reset) begin
         clear_parser();
         pending_uuids.delete();
      end else begin
         if (req_valid && req_ready)
            parse_char(req_character, req_last_char);
         if (rsp_valid && rsp_ready) begin
            if (pending_uuids.size() == 0) begin
               if (fails < 10)
                  $display("%0t: unexpected response ok=%0b high=%h low=%h",
                           $realtime, rsp_parse_ok, rsp_uuid_high, rsp_uuid_low);
               fails++;
            end else begin
               want = pending_uuids.pop_front();
               if (rsp_parse_ok !== want.ok || rsp_uuid_high !== want.high ||
                   rsp_uuid_low !== want.low) begin
                  if (fails < 10)
                     $display("%0t: expected ok=%0b hi=%h lo=%h, got ok=%0b hi=%h lo=%h",
                              $realtime, want.ok, want.high, want.low,
                              rsp_parse_ok, rsp_uuid_high, rsp_uuid_low);
                  fails++;
               end
            end
         end
      end
      waiting <= pending_uuids.size();
   end

endmodule

[tb/sv/testbench.sv]
// Top of the UUID text parser testbench: clock, reset, text stimulus and verdict.
// Depends on uuidp_pkg, uuidp_if.sv, uuid_text_parser and uuidp_checker.
`timescale 1ns / 1ps

module testbench;

   typedef logic [7:0] text_type[$];

   typedef enum int {STALL_NONE, STALL_HALF, STALL_MOST} stall_mode_type;
   typedef enum int {DAMAGE_SWAP, DAMAGE_DASH, DAMAGE_DROP, DAMAGE_CUT, DAMAGE_TAIL,
                     DAMAGE_DIGIT} damage_kind_type;

   logic clock;
   logic reset;
   logic pressure_start;
   int   error_count;
   int   pending_count;
   int   burst_left = 0;
   int   chars_sent = 0;

   uuidp_req_if req_bus ();
   uuidp_rsp_if rsp_bus ();

   uuid_text_parser uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   uuidp_checker uuid_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_character (req_bus.character),
      .req_last_char (req_bus.last_char),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_parse_ok  (rsp_bus.parse_ok),
      .rsp_uuid_high (rsp_bus.uuid_high),
      .rsp_uuid_low  (rsp_bus.uuid_low),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Stall responses on a changing pattern; hold off once for a long stretch
   initial begin
      int             window;
      int             hold_left;
      bit             hold_done;
      stall_mode_type mode;
      rsp_bus.ready <= 1'b0;
      window    = 0;
      hold_left = 0;
      hold_done = 1'b0;
      mode      = STALL_NONE;
      forever begin
         @(posedge clock);
         if (pressure_start && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (window == 0) begin
            window = $urandom_range(20, 200);
            mode   = stall_mode_type'($urandom_range(0, 2));
         end
         window--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               STALL_NONE: rsp_bus.ready <= 1'b1;
               STALL_HALF: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default:    rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic text_type text_of(input string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) return uuidp_pkg::DIGIT_ZERO + nib;
      return (upper ? uuidp_pkg::UPPER_A : uuidp_pkg::LOWER_A) + nib - 8'd10;
   endfunction

   // Build a well-formed UUID text with random digits, case and hyphen layout
   function automatic text_type make_uuid();
      text_type   t;
      int         layout;
      bit         dash;
      logic [7:0] value;
      layout = $urandom_range(0, 3);
      for (int b = 0; b < 16; b++) begin
         case (layout)
            0:       dash = 1'b0;
            1:       dash = (b == 4 || b == 6 || b == 8 || b == 10);
            2:       dash = ($urandom_range(0, 2) == 0);
            default: dash = 1'b1;
         endcase
         if (dash) t.push_back(uuidp_pkg::HYPHEN_CHAR);
         value = 8'($urandom_range(0, 255));
         t.push_back(hex_char(value[7:4], 1'($urandom_range(0, 1))));
         t.push_back(hex_char(value[3:0], 1'($urandom_range(0, 1))));
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) t.push_back(uuidp_pkg::HYPHEN_CHAR);
      return t;
   endfunction

   // Alter a well-formed text in one random way, which may break it
   function automatic text_type damage(input text_type t);
      int              pos;
      int              keep;
      damage_kind_type kind;
      pos  = $urandom_range(0, t.size() - 1);
      kind = damage_kind_type'($urandom_range(0, 5));
      case (kind)
         DAMAGE_SWAP: t[pos] = 8'($urandom_range(0, 255));
         DAMAGE_DASH: t.insert(pos, uuidp_pkg::HYPHEN_CHAR);
         DAMAGE_DROP: t.delete(pos);
         DAMAGE_CUT: begin
            keep = $urandom_range(1, t.size() - 1);
            while (t.size() > keep) void'(t.pop_back());
         end
         DAMAGE_TAIL: t.push_back(8'($urandom_range(0, 255)));
         default:     t.insert(pos, hex_char(4'($urandom_range(0, 15)),
                                             1'($urandom_range(0, 1))));
      endcase
      return t;
   endfunction

   function automatic text_type make_noise();
      text_type t;
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 2))
            0:       t.push_back(uuidp_pkg::HYPHEN_CHAR);
            1:       t.push_back(hex_char(4'($urandom_range(0, 15)),
                                          1'($urandom_range(0, 1))));
            default: t.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      return t;
   endfunction

   // Offer one string in bursts, flagging its final character
   task automatic send_text(input text_type t);
      for (int i = 0; i < t.size(); i++) begin
         if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 16);
         end
         req_bus.valid     <= 1'b1;
         req_bus.character <= t[i];
         req_bus.last_char <= (i == t.size() - 1);
         @(negedge clock);
         while (!req_bus.ready) @(negedge clock);
         @(posedge clock);
         burst_left--;
         chars_sent++;
      end
   endtask

   initial begin
      text_type   t;
      logic [7:0] edge_chars[8];
      int         random_goal;
      edge_chars = '{8'h00, 8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'hFF};
      reset             <= 1'b1;
      pressure_start    <= 1'b0;
      req_bus.valid     <= 1'b0;
      req_bus.character <= 8'h00;
      req_bus.last_char <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: layouts, extremes and each way a string can fail
      send_text(text_of("00112233-4455-6677-8899-aabbccddeeff"));
      send_text(text_of("FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF"));
      send_text(text_of("-00-00-00-00-00-00-00-00-00-00-00-00-00-00-00-00"));
      send_text(text_of("0123456789abcdefABCDEF0123456789---"));
      send_text(text_of("01234567-89ab-cdeg-0123-456789abcdef"));
      send_text(text_of("01234567--89ab-cdef-0123-456789abcdef"));
      send_text(text_of("0-123456789abcdef0123456789abcdef"));
      send_text(text_of("0123456789abcdef0123456789abcde"));
      send_text(text_of("0123456789abcdef0123456789abcd"));
      send_text(text_of("0123456789abcdef0123456789abcdef-x"));
      send_text(text_of("0123456789abcdef0123456789abcdef00"));
      send_text(text_of("-"));
      send_text(text_of("a"));
      foreach (edge_chars[i]) begin
         t = {8'h31, edge_chars[i]};
         send_text(t);
      end

      // fill the block while the receiver holds off
      pressure_start <= 1'b1;
      repeat (40) begin
         if ($urandom_range(0, 3) == 0) send_text(make_uuid());
         else send_text(make_noise());
      end

      // random: mostly well-formed strings, some broken, some noise
      random_goal = 1300;
      while (chars_sent < random_goal) begin
         case ($urandom_range(0, 19))
            0, 1:                  send_text(make_noise());
            2, 3, 4, 5, 6:         send_text(damage(make_uuid()));
            default:               send_text(make_uuid());
         endcase
      end
      req_bus.valid <= 1'b0;

      // drain outstanding results, then allow for late extras
      @(negedge clock);
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
